>>> rtl/cft_pkg.sv
`default_nettype none

package cft_pkg;

  // Character width and fixed codes
  localparam int unsigned CharW = 8;
  localparam logic [CharW-1:0] LineFeed = 8'd10;
  localparam logic [CharW-1:0] SepReset = 8'd44;
  localparam logic [CharW-1:0] DelimReset = 8'd34;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgSeparator = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDelimiter = 1'b1;

  // Work queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Work word: what one character causes on the result side
  typedef struct packed {
    logic [CharW-1:0] ch;        // character to emit as content
    logic [1:0]       nchar;     // number of content copies, 0 to 2
    logic             mark;      // a mark result follows the content
    logic             field_end;
    logic             record_end;
    logic             dropped;
  } work_t;

endpackage : cft_pkg

`default_nettype wire

>>> rtl/cft_front.sv
`default_nettype none

module cft_front
  import cft_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [CharW-1:0] in_char_i,
  input  wire logic             final_char_i,
  input  wire logic [CharW-1:0] sep_i,
  input  wire logic [CharW-1:0] delim_i,
  output work_t                 work_o,
  output logic                  has_work_o
);

  typedef enum logic [3:0] {
    SC_START  = 4'b0001,
    SC_PLAIN  = 4'b0010,
    SC_QUOTED = 4'b0100,
    SC_SKIP   = 4'b1000
  } scope_e;

  typedef enum logic [2:0] {
    RUN_NONE = 3'b001,
    RUN_ONE  = 3'b010,
    RUN_MANY = 3'b100
  } run_e;

  scope_e scope_q, scope_d;
  run_e   run_q, run_d;

  logic is_lf, is_sep, is_delim;
  logic [1:0] nchar;
  logic mark, fe, re, dr;

  assign is_lf    = (in_char_i == LineFeed);
  assign is_sep   = (in_char_i == sep_i);
  assign is_delim = (in_char_i == delim_i);

  // Classify the character against the current scope
  always_comb begin
    scope_d = scope_q;
    run_d   = run_q;
    nchar   = 2'd0;
    mark    = 1'b0;
    fe      = 1'b0;
    re      = 1'b0;
    dr      = 1'b0;

    unique case (scope_q)
      SC_PLAIN: begin
        if (is_lf) begin
          mark = 1'b1; fe = 1'b1; re = 1'b1;
          scope_d = SC_START;
        end else if (is_sep) begin
          mark = 1'b1; fe = 1'b1;
          scope_d = SC_START;
        end else begin
          nchar = 2'd1;
        end
      end
      SC_QUOTED: begin
        if ((run_q == RUN_ONE) && !is_delim) begin
          // single pending delimiter closes the field
          mark = 1'b1; fe = 1'b1;
          run_d = RUN_NONE;
          if (is_lf) begin
            re = 1'b1;
            scope_d = SC_START;
          end else if (is_sep) begin
            scope_d = SC_START;
          end else begin
            scope_d = SC_SKIP;
          end
        end else if (is_lf) begin
          nchar = 2'd1;
          run_d = RUN_NONE;
        end else if (is_delim) begin
          unique case (run_q)
            RUN_ONE: begin
              nchar = 2'd2;
              run_d = RUN_MANY;
            end
            RUN_MANY: begin
              nchar = 2'd1;
              run_d = RUN_MANY;
            end
            default: run_d = RUN_ONE;
          endcase
        end else begin
          nchar = 2'd1;
          run_d = RUN_NONE;
        end
      end
      SC_SKIP: begin
        if (is_lf) begin
          mark = 1'b1; re = 1'b1;
          scope_d = SC_START;
        end else if (is_sep) begin
          scope_d = SC_START;
        end
      end
      default: begin
        if (is_lf) begin
          mark = 1'b1; re = 1'b1;
        end else if (is_delim) begin
          scope_d = SC_QUOTED;
          run_d   = RUN_MANY;
        end else if (is_sep) begin
          mark = 1'b1; fe = 1'b1;
        end else begin
          nchar = 2'd1;
          scope_d = SC_PLAIN;
        end
      end
    endcase

    // Close out the input on its last character; marks merge into one word
    if (final_char_i) begin
      unique case (scope_d)
        SC_PLAIN: begin
          mark = 1'b1; fe = 1'b1; re = 1'b1;
        end
        SC_QUOTED: begin
          mark = 1'b1; re = 1'b1;
          if (run_d == RUN_ONE) begin
            fe = 1'b1;
          end else begin
            dr = 1'b1;
          end
        end
        SC_SKIP: begin
          mark = 1'b1; re = 1'b1;
        end
        default: begin
          if (!is_lf) begin
            mark = 1'b1; re = 1'b1;
          end
        end
      endcase
      scope_d = SC_START;
      run_d   = RUN_NONE;
    end
  end

  assign work_o = '{ch: in_char_i, nchar: nchar, mark: mark,
                    field_end: fe, record_end: re, dropped: dr};
  assign has_work_o = (nchar != 2'd0) || mark;

  // Advance scope on each accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scope_q <= SC_START;
      run_q   <= RUN_NONE;
    end else if (accept_i) begin
      scope_q <= scope_d;
      run_q   <= run_d;
    end
  end

endmodule : cft_front

`default_nettype wire

>>> rtl/cft_queue.sv
`default_nettype none

module cft_queue
  import cft_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_en_i,
  input  wire work_t wr_word_i,
  input  wire logic  rd_en_i,
  output work_t      rd_word_o,
  output logic       full_o,
  output logic       empty_o
);

  work_t mem_q [QueueDepth];

  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_wr, do_rd;

  assign full_o    = (count_q == QueueCntW'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_word_o = mem_q[rd_ptr_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule : cft_queue

`default_nettype wire

>>> rtl/cft_back.sv
`default_nettype none

module cft_back
  import cft_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire work_t            q_word_i,
  output logic                  q_pop_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [CharW-1:0]      out_char_o,
  output logic                  char_valid_o,
  output logic                  field_end_o,
  output logic                  record_end_o,
  output logic                  field_dropped_o,
  output logic                  last_of_run_o
);

  work_t      word_q;
  logic [1:0] cnt_q;
  logic       busy_q;
  logic       is_char, is_last, take, load;

  assign is_char = (cnt_q != 2'd0);
  assign is_last = !is_char || ((cnt_q == 2'd1) && !word_q.mark);
  assign take    = pop_i && busy_q;
  assign load    = !q_empty_i && (!busy_q || (take && is_last));
  assign q_pop_o = load;
  assign empty_o = !busy_q;

  // Present the current result from the held word
  assign out_char_o      = is_char ? word_q.ch : '0;
  assign char_valid_o    = is_char;
  assign field_end_o     = !is_char && word_q.field_end;
  assign record_end_o    = !is_char && word_q.record_end;
  assign field_dropped_o = !is_char && word_q.dropped;
  assign last_of_run_o   = is_last;

  // Hold the word payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= q_word_i;
    end
  end

  // Step through the results of the held word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= q_word_i.nchar;
    end else if (take) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule : cft_back

`default_nettype wire

>>> rtl/csv_field_tokenizer.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------
// input    | push / full                | in_char_i, final_char_i
// result   | empty / pop                | out_char_o, char_valid_o, field_end_o,
//          |                            | record_end_o, field_dropped_o, last_of_run_o
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One character per cycle is accepted unless full; it is classified in that cycle.
// Each character yields 0 to 3 results, handed out one per cycle while pop is high.
// A four-word queue between front and back raises full when the back falls behind.
// Reset returns the scope to field start and the registers to comma and double quote.
// Config writes are always ready and take effect on the next character.
`default_nettype none

module csv_field_tokenizer
  import cft_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [CharW-1:0]     in_char_i,
  input  wire logic                 final_char_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [CharW-1:0]          out_char_o,
  output logic                      char_valid_o,
  output logic                      field_end_o,
  output logic                      record_end_o,
  output logic                      field_dropped_o,
  output logic                      last_of_run_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CharW-1:0]     cfg_data_i
);

  logic [CharW-1:0] sep_q, delim_q;
  logic             accept, has_work, q_empty, q_pop;
  work_t            front_word, q_word;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SepReset;
      delim_q <= DelimReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgSeparator: sep_q   <= cfg_data_i;
        CfgDelimiter: delim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_char_i    (in_char_i),
    .final_char_i (final_char_i),
    .sep_i        (sep_q),
    .delim_i      (delim_q),
    .work_o       (front_word),
    .has_work_o   (has_work)
  );

  cft_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && has_work),
    .wr_word_i (front_word),
    .rd_en_i   (q_pop),
    .rd_word_o (q_word),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  cft_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_word_i        (q_word),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .out_char_o      (out_char_o),
    .char_valid_o    (char_valid_o),
    .field_end_o     (field_end_o),
    .record_end_o    (record_end_o),
    .field_dropped_o (field_dropped_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule : csv_field_tokenizer

`default_nettype wire

>>> tb/csv_field_tokenizer_checker.sv
`timescale 1ns / 100ps

module csv_field_tokenizer_checker
  import cft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [CharW-1:0]   in_char_i,
  input  logic               final_char_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [CharW-1:0]   out_char_i,
  input  logic               char_valid_i,
  input  logic               field_end_i,
  input  logic               record_end_i,
  input  logic               field_dropped_i,
  input  logic               last_of_run_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CharW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef enum logic [1:0] {ScopeStart, ScopePlain, ScopeQuoted, ScopeSkip} scope_e;
  typedef enum logic [1:0] {RunNone, RunOne, RunLong} run_e;

  // One result word as it leaves the block
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             valid;
    logic             fe;
    logic             re;
    logic             dropped;
    logic             last;
  } token_t;

  token_t           token_q[$];
  token_t           step_buf[3];
  int               step_cnt;
  int               fail_cnt;
  int               checked_cnt;
  logic [CharW-1:0] sep_r;
  logic [CharW-1:0] delim_r;
  scope_e           scope_r;
  run_e             run_r;

  // Add a content word for the current character
  function automatic void emit_char(logic [CharW-1:0] c);
    token_t t;
    t = '0;
    t.ch = c;
    t.valid = 1'b1;
    if (step_cnt < 3) begin
      step_buf[step_cnt] = t;
      step_cnt++;
    end
  endfunction

  // Merge marks into a trailing mark word until it carries a record end
  function automatic void emit_mark(logic fe, logic re, logic dr);
    token_t t;
    t = '0;
    t.fe = fe;
    t.re = re;
    t.dropped = dr;
    if (step_cnt > 0 && !step_buf[step_cnt-1].valid && !step_buf[step_cnt-1].re) begin
      step_buf[step_cnt-1].fe |= fe;
      step_buf[step_cnt-1].re |= re;
      step_buf[step_cnt-1].dropped |= dr;
    end else if (step_cnt < 3) begin
      step_buf[step_cnt] = t;
      step_cnt++;
    end
  endfunction

  // Advance the tokenizer state by one character and queue its words
  function automatic void tokenize_char(logic [CharW-1:0] c, logic fin);
    logic lf;
    lf = (c == LineFeed);
    step_cnt = 0;
    case (scope_r)
      ScopeStart: begin
        if (lf) begin
          emit_mark(1'b0, 1'b1, 1'b0);
        end else if (c == delim_r) begin
          scope_r = ScopeQuoted;
          run_r = RunLong;
        end else if (c == sep_r) begin
          emit_mark(1'b1, 1'b0, 1'b0);
        end else begin
          emit_char(c);
          scope_r = ScopePlain;
        end
      end
      ScopePlain: begin
        if (lf) begin
          emit_mark(1'b1, 1'b1, 1'b0);
          scope_r = ScopeStart;
        end else if (c == sep_r) begin
          emit_mark(1'b1, 1'b0, 1'b0);
          scope_r = ScopeStart;
        end else begin
          emit_char(c);
        end
      end
      ScopeQuoted: begin
        if (run_r == RunOne && c != delim_r) begin
          // a lone delimiter closes the field; this character is skip text
          emit_mark(1'b1, 1'b0, 1'b0);
          run_r = RunNone;
          if (lf) begin
            emit_mark(1'b0, 1'b1, 1'b0);
            scope_r = ScopeStart;
          end else if (c == sep_r) begin
            scope_r = ScopeStart;
          end else begin
            scope_r = ScopeSkip;
          end
        end else if (lf) begin
          emit_char(c);
          run_r = RunNone;
        end else if (c == delim_r) begin
          if (run_r == RunNone) begin
            run_r = RunOne;
          end else begin
            // a pending one turns into a literal pair
            if (run_r == RunOne) emit_char(c);
            emit_char(c);
            run_r = RunLong;
          end
        end else begin
          emit_char(c);
          run_r = RunNone;
        end
      end
      default: begin
        if (lf) begin
          emit_mark(1'b0, 1'b1, 1'b0);
          scope_r = ScopeStart;
        end else if (c == sep_r) begin
          scope_r = ScopeStart;
        end
      end
    endcase

    // Close whatever is open at end of input
    if (fin) begin
      case (scope_r)
        ScopePlain:  emit_mark(1'b1, 1'b1, 1'b0);
        ScopeQuoted: begin
          if (run_r == RunOne) emit_mark(1'b1, 1'b1, 1'b0);
          else emit_mark(1'b0, 1'b1, 1'b1);
        end
        ScopeSkip:   emit_mark(1'b0, 1'b1, 1'b0);
        default: begin
          if (!lf) emit_mark(1'b0, 1'b1, 1'b0);
        end
      endcase
      scope_r = ScopeStart;
      run_r = RunNone;
    end

    if (step_cnt > 0) step_buf[step_cnt-1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) token_q.push_back(step_buf[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Track config, predict accepted characters, compare popped words
  always @(posedge clk_i or negedge rst_ni) begin
    token_t exp_w;
    if (!rst_ni) begin
      sep_r = SepReset;
      delim_r = DelimReset;
      scope_r = ScopeStart;
      run_r = RunNone;
      token_q.delete();
      fail_cnt = 0;
      checked_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSeparator: sep_r = cfg_data_i;
          CfgDelimiter: delim_r = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) tokenize_char(in_char_i, final_char_i);
      if (pop_i && !empty_i) begin
        if (token_q.size() == 0) begin
          $error("result word with nothing expected: out_char %0d", out_char_i);
          fail_cnt++;
        end else begin
          exp_w = token_q.pop_front();
          checked_cnt++;
          check_field("out_char", exp_w.ch, out_char_i);
          check_field("char_valid", exp_w.valid, char_valid_i);
          check_field("field_end", exp_w.fe, field_end_i);
          check_field("record_end", exp_w.re, record_end_i);
          check_field("field_dropped", exp_w.dropped, field_dropped_i);
          check_field("last_of_run", exp_w.last, last_of_run_i);
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o <= token_q.size();
    checked_o <= checked_cnt;
  end

endmodule

>>> tb/tb_csv_field_tokenizer.sv
`timescale 1ns / 100ps

module tb_csv_field_tokenizer;
  import cft_pkg::*;

  localparam int QuietLimit = 400;
  localparam int NumPhases = 6;
  localparam int WordsPerHalf = 6;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic [CharW-1:0]   in_char = '0;
  logic               final_char = 1'b0;
  logic               pop = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgSeparator;
  logic [CharW-1:0]   cfg_data = '0;
  logic               full;
  logic               empty;
  logic [CharW-1:0]   out_char;
  logic               char_valid;
  logic               field_end;
  logic               record_end;
  logic               field_dropped;
  logic               last_of_run;
  logic               cfg_ready;
  int                 fail_count;
  int                 pending;
  int                 checked;

  logic               send_idle = 1'b1;
  logic               recv_idle = 1'b1;
  logic [CharW-1:0]   cur_sep = SepReset;
  logic [CharW-1:0]   cur_delim = DelimReset;
  int                 n_sent = 0;
  int                 quiet = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  csv_field_tokenizer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_char_i       (in_char),
    .final_char_i    (final_char),
    .empty           (empty),
    .pop             (pop),
    .out_char_o      (out_char),
    .char_valid_o    (char_valid),
    .field_end_o     (field_end),
    .record_end_o    (record_end),
    .field_dropped_o (field_dropped),
    .last_of_run_o   (last_of_run),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  csv_field_tokenizer_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .in_char_i       (in_char),
    .final_char_i    (final_char),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_char_i      (out_char),
    .char_valid_i    (char_valid),
    .field_end_i     (field_end),
    .record_end_i    (record_end),
    .field_dropped_i (field_dropped),
    .last_of_run_i   (last_of_run),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // End the run after too long without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("FAIL csv_field_tokenizer");
      $finish;
    end
  end

  // Drain result words, with a random stall before each when recv_idle is set
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  // Offer one character and hold it until the block takes it
  task automatic send_char(input logic [CharW-1:0] c, input logic fin);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_char <= c;
    final_char <= fin;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  // Hold off input until every expected word is out, then let the block settle
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_chars(input logic [CharW-1:0] sep, input logic [CharW-1:0] delim);
    cfg_valid <= 1'b1;
    cfg_index <= CfgSeparator;
    cfg_data <= sep;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= CfgDelimiter;
    cfg_data <= delim;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sep = sep;
    cur_delim = delim;
  endtask

  // Ordinary content: never a separator, delimiter or line feed
  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255));
    while (c == cur_sep || c == cur_delim || c == LineFeed);
    return c;
  endfunction

  // Send a record of empty, plain and quoted fields, some with skip text
  task automatic send_record();
    int nf;
    int kind;
    int len;
    int r;
    nf = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      kind = $urandom_range(0, 9);
      if (kind >= 6) begin
        send_char(cur_delim, 1'b0);
        send_char(plain_char(), 1'b0);
        len = $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 5);
          if (r == 0) begin
            send_char(LineFeed, 1'b0);
          end else if (r == 1) begin
            send_char(cur_delim, 1'b0);
            send_char(cur_delim, 1'b0);
          end
          send_char(plain_char(), 1'b0);
        end
        send_char(cur_delim, 1'b0);
        if ($urandom_range(0, 3) == 0) send_char(plain_char(), 1'b0);
      end else if (kind >= 1) begin
        len = $urandom_range(1, 5);
        repeat (len) send_char(plain_char(), 1'b0);
      end
      if (f < nf - 1) send_char(cur_sep, 1'b0);
      else send_char(LineFeed, $urandom_range(0, 4) == 0);
    end
  endtask

  // Send a short burst of arbitrary characters, biased to the special ones
  task automatic send_noise();
    int n;
    int r;
    logic [CharW-1:0] c;
    n = $urandom_range(1, 3);
    repeat (n) begin
      r = $urandom_range(0, 5);
      case (r)
        0: c = cur_sep;
        1: c = cur_delim;
        2: c = LineFeed;
        default: c = CharW'($urandom_range(0, 255));
      endcase
      send_char(c, $urandom_range(0, 24) == 0);
    end
  endtask

  task automatic send_random(input int count);
    int start;
    start = n_sent;
    while (n_sent - start < count) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_record();
    end
  endtask

  initial begin
    logic [CharW-1:0] dir_chars [25];
    logic [CharW-1:0] phase_sep [NumPhases];
    logic [CharW-1:0] phase_delim [NumPhases];

    // empty line, empty field, extreme bytes, quoted with pairs and skip text,
    // quoted line feed, long delimiter run, closer/plain/open quote at input end
    dir_chars = '{LineFeed, SepReset, 8'h00, 8'hFF, LineFeed,
                  DelimReset, "a", DelimReset, DelimReset, "b", DelimReset, "x", SepReset,
                  DelimReset, LineFeed, DelimReset, LineFeed,
                  DelimReset, DelimReset, DelimReset, "z", DelimReset,
                  "q", DelimReset, "w"};
    phase_sep = '{SepReset, 8'd255, 8'd59, LineFeed, 8'd0, 8'd9};
    phase_delim = '{DelimReset, 8'd0, 8'd59, LineFeed, 8'd255, 8'd39};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 25; i++) send_char(dir_chars[i], i == 21 || i == 22 || i == 24);

    for (int p = 0; p < NumPhases; p++) begin
      // vary which side idles so some stretches run back to back
      send_idle = (p % 3 != 2);
      recv_idle = (p % 3 != 1);
      if (p > 0) begin
        wait_drained();
        set_chars(phase_sep[p], phase_delim[p]);
      end
      send_random(WordsPerHalf);
      wait_drained();
      send_random(WordsPerHalf);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d characters under %0d separator/delimiter settings,", n_sent,
             NumPhases);
    $display("with %0d result words compared against the prediction.", checked);
    if (fail_count == 0) begin
      $display("PASS csv_field_tokenizer");
    end else begin
      $display("FAIL csv_field_tokenizer");
    end
    $finish;
  end

endmodule
